### design/kmw_pkg.sv
package kmw_pkg;

  // Request codes of the input channel
  localparam logic [2:0] REQ_BEGIN     = 3'd0;
  localparam logic [2:0] REQ_LOAD      = 3'd1;
  localparam logic [2:0] REQ_LOAD_DONE = 3'd2;
  localparam logic [2:0] REQ_NEXT      = 3'd3;
  localparam logic [2:0] REQ_REPLY     = 3'd4;
  localparam logic [2:0] REQ_EXHAUSTED = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_LIVE    = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;
  localparam logic [1:0] KIND_ENDED   = 2'd3;

  localparam int unsigned SRC_BITS = 3;
  localparam int unsigned PRIO_BITS = 4;
  localparam logic [31:0] PRIO_MAP_RESET = 32'h7654_3210;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LOADING,
    MODE_LIVE,
    MODE_AWAIT,
    MODE_ENDED
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAP_LD,
    S_SINK_L,
    S_SINK_R,
    S_TAIL_RD,
    S_TOP_RD,
    S_TOP,
    S_DONE
  } seq_t;

endpackage

### design/kmw_req_if.sv
interface kmw_req_if #(
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            req_type;
  logic [2:0]            source_id;
  logic [KEY_BITS-1:0]   entry_key;
  logic                  entry_tombstone;
  logic [VALUE_BITS-1:0] entry_value;

  modport source (output valid, req_type, source_id, entry_key, entry_tombstone,
                  entry_value, input ready);
  modport sink (input valid, req_type, source_id, entry_key, entry_tombstone,
                entry_value, output ready);
endinterface

### design/kmw_rsp_if.sv
interface kmw_rsp_if #(
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            out_kind;
  logic [2:0]            out_source;
  logic [KEY_BITS-1:0]   out_key;
  logic [VALUE_BITS-1:0] out_value;

  modport source (output valid, out_kind, out_source, out_key, out_value, input ready);
  modport sink (input valid, out_kind, out_source, out_key, out_value, output ready);
endinterface

### design/kmw_cfg_if.sv
interface kmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/kmw_heap_store.sv
module kmw_heap_store #(
  parameter int W = 132,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] slots [DEPTH];

  // Write one slot a cycle, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
    rdata <= slots[raddr];
  end
endmodule

### design/kmw_cmp.sv
module kmw_cmp
  import kmw_pkg::*;
#(
  parameter int KEY_BITS = 64
) (
  input  logic [KEY_BITS-1:0]  a_key,
  input  logic [PRIO_BITS-1:0] a_prio,
  input  logic [KEY_BITS-1:0]  b_key,
  input  logic [PRIO_BITS-1:0] b_prio,
  output logic                 a_first
);
  // Order by key, then by source priority
  always_comb begin
    if (a_key != b_key) begin
      a_first = a_key < b_key;
    end else begin
      a_first = a_prio < b_prio;
    end
  end
endmodule

### design/k_way_merge_with_tombstones.sv
// K-way merge of sorted sources through a min-heap of cached head entries.
// Channels: req carries requests (begin, load head, load done, consumer next,
// reply entry, reply exhausted); rsp returns exactly one item per request
// (nothing, live entry, advance request, merge ended); cfg writes the
// priority map, four bits per source, lower wins on equal keys.
// Begin, loads and ignored requests go straight to the result; consumer
// next settles the current top. A reply sifts down on the shared compare
// unit one level at a time, then the top is fetched and settled; reply
// exhausted first fetches the tail entry. Load done runs count/2 sift-downs,
// fetching each node first. The block takes one request at a time;
// req.ready is high only while the sequencer is idle, and the next request
// may enter while the last result still waits in the output register.
// Reset clears the mode to idle, empties the heap and restores the priority
// map to 0x76543210; heap slots hold no reset value. When the receiver
// stalls, the finished item waits in the output register and the sequencer
// holds its next item until the register frees.
module k_way_merge_with_tombstones
  import kmw_pkg::*;
#(
  parameter int SOURCES = 8,
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
) (
  input logic clk,
  input logic rst,
  kmw_req_if.sink   req,
  kmw_rsp_if.source rsp,
  kmw_cfg_if.sink   cfg
);
  localparam int IW = $clog2(SOURCES);
  localparam int CW = $clog2(SOURCES + 1);
  localparam int LW = IW + 2;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [SRC_BITS-1:0]   src;
    logic                  tomb;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

  seq_t                  state, state_next;
  mode_t                 mode, mode_next;
  logic [CW-1:0]         count, count_next;
  logic [KEY_BITS-1:0]   match_key, match_key_next;
  logic [2:0]            awaited, awaited_next;
  logic [31:0]           prio_map;
  entry_t                cur, cur_next;
  entry_t                best, best_next;
  logic [IW-1:0]         best_idx, best_idx_next;
  logic [IW-1:0]         node, node_next;
  logic [IW-1:0]         hloop, hloop_next;
  logic                  heapify, heapify_next;
  logic                  cont, cont_next;
  logic [1:0]            r_kind, r_kind_next;
  logic [2:0]            r_src, r_src_next;
  logic [KEY_BITS-1:0]   r_key, r_key_next;
  logic [VALUE_BITS-1:0] r_val, r_val_next;
  logic                  out_valid;
  logic [1:0]            out_kind;
  logic [2:0]            out_src;
  logic [KEY_BITS-1:0]   out_key;
  logic [VALUE_BITS-1:0] out_val;

  logic                  we;
  logic [IW-1:0]         waddr;
  entry_t                wdata;
  logic [IW-1:0]         raddr;
  entry_t                rd;
  logic                  rd_first;
  logic                  sink_fin;
  logic [LW-1:0]         l_idx, r_idx;
  logic                  l_ok, r_ok;
  logic                  accept, done_go;

  kmw_heap_store #(.W($bits(entry_t)), .DEPTH(SOURCES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  kmw_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a_key   (rd.key),
    .a_prio  (prio_map[{rd.src, 2'b00} +: PRIO_BITS]),
    .b_key   (best.key),
    .b_prio  (prio_map[{best.src, 2'b00} +: PRIO_BITS]),
    .a_first (rd_first)
  );

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign done_go = !out_valid || rsp.ready;

  assign l_idx = LW'({node, 1'b1});
  assign r_idx = LW'({node, 1'b0}) + LW'(2);
  assign l_ok = l_idx < LW'(count);
  assign r_ok = r_idx < LW'(count);

  assign rsp.valid = out_valid;
  assign rsp.out_kind = out_kind;
  assign rsp.out_source = out_src;
  assign rsp.out_key = out_key;
  assign rsp.out_value = out_val;

  // Sequencer: decode requests and step the sift-down
  always_comb begin
    state_next = state;
    mode_next = mode;
    count_next = count;
    match_key_next = match_key;
    awaited_next = awaited;
    cur_next = cur;
    best_next = best;
    best_idx_next = best_idx;
    node_next = node;
    hloop_next = hloop;
    heapify_next = heapify;
    cont_next = cont;
    r_kind_next = r_kind;
    r_src_next = r_src;
    r_key_next = r_key;
    r_val_next = r_val;
    we = 1'b0;
    waddr = node;
    wdata = cur;
    raddr = '0;
    sink_fin = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          r_kind_next = KIND_NONE;
          r_src_next = '0;
          r_key_next = '0;
          r_val_next = '0;
          state_next = S_DONE;
          case (req.req_type)
            REQ_BEGIN: begin
              count_next = '0;
              mode_next = MODE_LOADING;
            end
            REQ_LOAD: begin
              if (mode == MODE_LOADING && count < CW'(SOURCES)) begin
                we = 1'b1;
                waddr = IW'(count);
                wdata = '{key: req.entry_key, src: req.source_id,
                          tomb: req.entry_tombstone, val: req.entry_value};
                count_next = count + CW'(1);
              end
            end
            REQ_LOAD_DONE: begin
              if (mode == MODE_LOADING) begin
                cont_next = 1'b0;
                if ((count >> 1) != '0) begin
                  heapify_next = 1'b1;
                  hloop_next = IW'((count >> 1) - CW'(1));
                  node_next = IW'((count >> 1) - CW'(1));
                  state_next = S_HEAP_LD;
                end else begin
                  state_next = S_TOP;
                end
              end
            end
            REQ_NEXT: begin
              if (mode == MODE_LIVE) begin
                cont_next = 1'b1;
                state_next = S_TOP;
              end else if (mode == MODE_ENDED) begin
                r_kind_next = KIND_ENDED;
              end
            end
            REQ_REPLY: begin
              if (mode == MODE_AWAIT && req.source_id == awaited && count != '0) begin
                cur_next = '{key: req.entry_key, src: req.source_id,
                             tomb: req.entry_tombstone, val: req.entry_value};
                best_next = '{key: req.entry_key, src: req.source_id,
                              tomb: req.entry_tombstone, val: req.entry_value};
                best_idx_next = '0;
                node_next = '0;
                heapify_next = 1'b0;
                cont_next = 1'b1;
                state_next = S_SINK_L;
              end
            end
            REQ_EXHAUSTED: begin
              if (mode == MODE_AWAIT && req.source_id == awaited && count != '0) begin
                count_next = count - CW'(1);
                node_next = '0;
                heapify_next = 1'b0;
                cont_next = 1'b1;
                state_next = (count != CW'(1)) ? S_TAIL_RD : S_TOP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HEAP_LD: begin
        cur_next = rd;
        best_next = rd;
        best_idx_next = node;
        state_next = S_SINK_L;
      end
      S_TAIL_RD: begin
        cur_next = rd;
        best_next = rd;
        best_idx_next = '0;
        state_next = S_SINK_L;
      end
      S_SINK_L: begin
        if (l_ok) begin
          if (rd_first) begin
            best_next = rd;
            best_idx_next = IW'(l_idx);
          end
          state_next = S_SINK_R;
        end else begin
          we = 1'b1;
          waddr = node;
          wdata = cur;
          sink_fin = 1'b1;
        end
      end
      S_SINK_R: begin
        if (r_ok && rd_first) begin
          we = 1'b1;
          waddr = node;
          wdata = rd;
          node_next = IW'(r_idx);
          best_next = cur;
          best_idx_next = IW'(r_idx);
          state_next = S_SINK_L;
        end else if (best_idx != node) begin
          we = 1'b1;
          waddr = node;
          wdata = best;
          node_next = best_idx;
          best_next = cur;
          state_next = S_SINK_L;
        end else begin
          we = 1'b1;
          waddr = node;
          wdata = cur;
          sink_fin = 1'b1;
        end
      end
      S_TOP_RD: begin
        state_next = S_TOP;
      end
      S_TOP: begin
        r_kind_next = KIND_NONE;
        r_src_next = '0;
        r_key_next = '0;
        r_val_next = '0;
        state_next = S_DONE;
        if (cont && count != '0 && rd.key == match_key) begin
          mode_next = MODE_AWAIT;
          awaited_next = rd.src;
          r_kind_next = KIND_ADVANCE;
          r_src_next = rd.src;
        end else if (count == '0) begin
          mode_next = MODE_ENDED;
          r_kind_next = KIND_ENDED;
        end else begin
          match_key_next = rd.key;
          if (rd.tomb) begin
            mode_next = MODE_AWAIT;
            awaited_next = rd.src;
            r_kind_next = KIND_ADVANCE;
            r_src_next = rd.src;
          end else begin
            mode_next = MODE_LIVE;
            r_kind_next = KIND_LIVE;
            r_src_next = rd.src;
            r_key_next = rd.key;
            r_val_next = rd.val;
          end
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Advance to the next heapify node or fetch the new top
    if (sink_fin) begin
      if (heapify && hloop != '0) begin
        hloop_next = hloop - IW'(1);
        node_next = hloop - IW'(1);
        state_next = S_HEAP_LD;
      end else begin
        state_next = S_TOP_RD;
      end
    end

    // Fetch the slot that the next state examines
    case (state_next)
      S_HEAP_LD: raddr = node_next;
      S_TAIL_RD: raddr = IW'(count_next);
      S_SINK_L:  raddr = IW'({node_next, 1'b1});
      S_SINK_R:  raddr = IW'(r_idx);
      default:   raddr = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_IDLE;
      count <= '0;
      match_key <= '0;
      awaited <= '0;
      prio_map <= PRIO_MAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      count <= count_next;
      match_key <= match_key_next;
      awaited <= awaited_next;
      if (cfg.valid) begin
        prio_map <= cfg.data;
      end
      if (state == S_DONE && done_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    best <= best_next;
    best_idx <= best_idx_next;
    node <= node_next;
    hloop <= hloop_next;
    heapify <= heapify_next;
    cont <= cont_next;
    r_kind <= r_kind_next;
    r_src <= r_src_next;
    r_key <= r_key_next;
    r_val <= r_val_next;
    if (state == S_DONE && done_go) begin
      out_kind <= r_kind;
      out_src <= r_src;
      out_key <= r_key;
      out_val <= r_val;
    end
  end
endmodule
